### rtl/sorted_unique_labels_macros.svh
// Assertion macros shared by the sorted unique labels RTL.
`ifndef SORTED_UNIQUE_LABELS_MACROS_SVH
`define SORTED_UNIQUE_LABELS_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define SUL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// cond implies prop in the same cycle
`define SUL_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// cond implies prop in the next cycle
`define SUL_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define SUL_ASSERT_ALWAYS(lbl, expr)
`define SUL_ASSERT_IMPL(lbl, cond, prop)
`define SUL_ASSERT_NEXT(lbl, cond, prop)

`endif

`endif

### rtl/sul_pkg.sv
// Shared types and constants of the sorted unique labels block.
package sul_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TOTAL_BITS = 7;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

### rtl/sul_cell.sv
// One cell of the sorted label chain: holds one label, compares, shifts.
module sul_cell import sul_pkg::*; #(
  parameter int LABEL_BITS = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [LABEL_BITS-1:0] ins_val,
  input  logic                  occ,
  input  logic [LABEL_BITS-1:0] left_val,
  input  logic                  left_less,
  input  logic [LABEL_BITS-1:0] right_val,
  output logic [LABEL_BITS-1:0] val,
  output logic                  less,
  output logic                  eq
);

  assign less = occ && (val < ins_val);
  assign eq   = occ && (val == ins_val);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        // keep smaller entries, take the new label at the boundary, push the rest right
        if (!less) begin
          val <= left_less ? ins_val : left_val;
        end
      end
      CELL_SHIFT: begin
        val <= right_val;
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule

### rtl/sorted_unique_labels.sv
// Sorted unique labels: collects a set of labels and returns its distinct values ascending.
//
// Input channel (in_valid / in_stall): one request per label, set_end high on the
// last label of a set. Only the low LABEL_BITS bits of a label are kept.
// Labels are taken at one per cycle in the load state; each one is compared against
// every cell of a chain of MAX_DISTINCT cells at once and inserted in that same
// cycle, so load rate is set by the combinational compare and shift of the cell chain.
// After the set_end request the input stalls while the chain shifts out toward
// cell 0, one distinct value per cycle unless the output stalls, into the output register.
// Output channel (out_valid / out_stall): taking the set_end request moves the block
// into the emit state, from which the first result is loaded into the output register.
// A stall on the output holds the result and freezes the chain; the input reopens
// as soon as the last result sits in the output register.
// Each result carries the distinct total, run_last on the final one, and the
// overflow flag, set when a new distinct label found the chain full and was dropped.
// Reset empties the chain (count and overflow flag clear) and drops any pending
// result; no sweep of the cells is needed.
module sorted_unique_labels import sul_pkg::*; #(
  parameter int MAX_DISTINCT = 64,
  parameter int LABEL_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] label,
  input  logic                  set_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] unique_value,
  output logic [TOTAL_BITS-1:0] unique_total,
  output logic                  run_last,
  output logic                  overflowed
);

  `include "sorted_unique_labels_macros.svh"

  localparam int CW = $clog2(MAX_DISTINCT + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic                  ovf;
  logic [CW-1:0]         remain;
  logic [TOTAL_BITS-1:0] set_total;
  logic                  set_ovf;

  logic [LABEL_BITS-1:0] ins_val;
  logic [LABEL_BITS-1:0] cell_val [MAX_DISTINCT];
  logic [MAX_DISTINCT-1:0] less_vec;
  logic [MAX_DISTINCT-1:0] eq_vec;
  logic [MAX_DISTINCT-1:0] occ_vec;
  cell_ctrl_t            ctrl;

  logic                  in_acc;
  logic                  dup;
  logic                  full;
  logic                  do_insert;
  logic                  out_go;
  logic [CW-1:0]         count_next;
  logic                  ovf_next;

  assign ins_val   = label[LABEL_BITS-1:0];
  assign in_stall  = (state != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign dup       = |eq_vec;
  assign full      = (count == CW'(MAX_DISTINCT));
  assign do_insert = in_acc && !dup && !full;
  assign out_go    = (state == ST_EMIT) && (!out_valid || !out_stall);

  assign count_next = do_insert ? count + CW'(1) : count;
  assign ovf_next   = ovf || (in_acc && !dup && full);

  always_comb begin
    ctrl.op = CELL_HOLD;
    if (do_insert) begin
      ctrl.op = CELL_INSERT;
    end else if (out_go) begin
      ctrl.op = CELL_SHIFT;
    end
  end

  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    logic [LABEL_BITS-1:0] left_val;
    logic                  left_less;
    logic [LABEL_BITS-1:0] right_val;

    assign occ_vec[i] = (count > CW'(i));

    if (i == 0) begin : g_head
      assign left_val  = ins_val;
      assign left_less = 1'b1;
    end else begin : g_body
      assign left_val  = cell_val[i-1];
      assign left_less = less_vec[i-1];
    end

    if (i == MAX_DISTINCT - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sul_cell #(
      .LABEL_BITS(LABEL_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ins_val  (ins_val),
      .occ      (occ_vec[i]),
      .left_val (left_val),
      .left_less(left_less),
      .right_val(right_val),
      .val      (cell_val[i]),
      .less     (less_vec[i]),
      .eq       (eq_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      unique_case_state: unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (set_end) begin
              // snapshot the set, then clear for the next one
              set_total <= TOTAL_BITS'(count_next);
              set_ovf   <= ovf_next;
              remain    <= count_next;
              count     <= '0;
              ovf       <= 1'b0;
              state     <= ST_EMIT;
            end else begin
              count <= count_next;
              ovf   <= ovf_next;
            end
          end
        end
        ST_EMIT: begin
          if (out_go) begin
            remain <= remain - CW'(1);
            if (remain == CW'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      if (out_go) begin
        out_valid    <= 1'b1;
        unique_value <= VALUE_BITS'(cell_val[0]);
        unique_total <= set_total;
        overflowed   <= set_ovf;
        run_last     <= (remain == CW'(1));
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SUL_ASSERT_ALWAYS(a_count_in_range, count <= CW'(MAX_DISTINCT))
  `SUL_ASSERT_IMPL(a_emit_has_work, state == ST_EMIT, remain != '0)
  `SUL_ASSERT_NEXT(a_end_clears, in_acc && set_end, state == ST_EMIT && count == '0 && !ovf)
  `SUL_ASSERT_NEXT(a_last_marked, out_go && remain == CW'(1),
                   out_valid && run_last && state == ST_LOAD)
  `SUL_ASSERT_IMPL(a_insert_only_load, do_insert, state == ST_LOAD && !full)

endmodule

### test/sorted_unique_labels_tb.sv
// Self-checking testbench for the sorted unique labels block.
module sorted_unique_labels_tb;
  import sul_pkg::*;

  localparam int MAX_DISTINCT = 64;
  localparam int LABEL_BITS   = 32;
  localparam int PLAN_ROWS    = 22;
  localparam int RANDOM_ITEMS = 195;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int BUSY_PCT     = 31;

  typedef enum int {SET_FULL, SET_FEW, SET_WIDE} set_kind_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [TOTAL_BITS-1:0] total;
    logic                  last;
    logic                  ovf;
  } unique_result_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] label;
    logic                  fin;
    logic                  typed;
    unique_result_t        want;
  } label_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] label = '0;
  logic                  set_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] unique_value;
  logic [TOTAL_BITS-1:0] unique_total;
  logic                  run_last;
  logic                  overflowed;

  sorted_unique_labels #(
    .MAX_DISTINCT(MAX_DISTINCT),
    .LABEL_BITS  (LABEL_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .label       (label),
    .set_end     (set_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .unique_value(unique_value),
    .unique_total(unique_total),
    .run_last    (run_last),
    .overflowed  (overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: ascending distinct labels of the open set.
  logic [VALUE_BITS-1:0] held_labels [MAX_DISTINCT];
  int                    held_count = 0;
  bit                    label_dropped = 1'b0;
  unique_result_t        awaited_uniques [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  sets_closed = 0;
  int  overflow_sets = 0;
  int  idle_pct = BUSY_PCT;
  bit  hold_wanted = 1'b0;
  int  cycle_count = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d, %s: got %h, want %h", results_seen, field, got, want);
    errors++;
  endtask

  // Insert one label into the held list; on a set end, queue the whole list or the typed result.
  task automatic absorb_label(input logic [VALUE_BITS-1:0] lbl, input logic fin,
                              input logic use_typed, input unique_result_t typed_want);
    logic [VALUE_BITS-1:0] v;
    int                    pos;
    unique_result_t        r;
    v = lbl & VALUE_BITS'((64'd1 << LABEL_BITS) - 1);
    pos = 0;
    while (pos < held_count && held_labels[pos] < v) pos++;
    if (!(pos < held_count && held_labels[pos] == v)) begin
      if (held_count >= MAX_DISTINCT) begin
        label_dropped = 1'b1;
      end else begin
        for (int k = held_count; k > pos; k--) held_labels[k] = held_labels[k-1];
        held_labels[pos] = v;
        held_count++;
      end
    end
    if (fin) begin
      if (use_typed) begin
        awaited_uniques.push_back(typed_want);
      end else begin
        for (int k = 0; k < held_count; k++) begin
          r.value = held_labels[k];
          r.total = TOTAL_BITS'(held_count);
          r.last  = (k == held_count - 1);
          r.ovf   = label_dropped;
          awaited_uniques.push_back(r);
        end
      end
      if (label_dropped) overflow_sets++;
      sets_closed++;
      held_count = 0;
      label_dropped = 1'b0;
    end
  endtask

  // Offer one request at the falling edge, hold it until taken.
  task automatic offer_label(input logic [VALUE_BITS-1:0] lbl, input logic fin,
                             input logic use_typed, input unique_result_t typed_want);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    label    <= lbl;
    set_end  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_label(lbl, fin, use_typed, typed_want);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic label_row_t mk_row(input logic [31:0] lbl, input logic fin,
                                        input logic typed, input logic [31:0] value,
                                        input logic [6:0] total, input logic last,
                                        input logic ovf);
    label_row_t row;
    row.label = lbl;
    row.fin = fin;
    row.typed = typed;
    row.want.value = value;
    row.want.total = total;
    row.want.last = last;
    row.want.ovf = ovf;
    return row;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    unique_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_uniques.size() == 0) begin
        report_mismatch("unexpected result", unique_value, '0);
      end else begin
        exp_r = awaited_uniques.pop_front();
        if (unique_value !== exp_r.value)
          report_mismatch("unique_value", unique_value, exp_r.value);
        if (unique_total !== exp_r.total)
          report_mismatch("unique_total", 32'(unique_total), 32'(exp_r.total));
        if (run_last !== exp_r.last)
          report_mismatch("run_last", 32'(run_last), 32'(exp_r.last));
        if (overflowed !== exp_r.ovf)
          report_mismatch("overflowed", 32'(overflowed), 32'(exp_r.ovf));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             awaited_uniques.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    label_row_t            plan [PLAN_ROWS];
    logic [VALUE_BITS-1:0] batch [0:127];
    logic [VALUE_BITS-1:0] tmp;
    int                    batch_len, n_new, n_rep, j, set_idx, random_sent;
    logic [31:0]           step, off;
    set_kind_t             kind;
    unique_result_t        none;

    none = '0;
    // single-label sets, extremes, a repeated label
    plan[0]  = mk_row(32'h0000_0000, 1, 1, 32'h0000_0000, 7'd1, 1, 0);
    plan[1]  = mk_row(32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 7'd1, 1, 0);
    plan[2]  = mk_row(32'h0000_0007, 0, 0, 0, 0, 0, 0);
    plan[3]  = mk_row(32'h0000_0007, 0, 0, 0, 0, 0, 0);
    plan[4]  = mk_row(32'h0000_0007, 1, 1, 32'h0000_0007, 7'd1, 1, 0);
    // descending arrival
    plan[5]  = mk_row(32'd30, 0, 0, 0, 0, 0, 0);
    plan[6]  = mk_row(32'd20, 0, 0, 0, 0, 0, 0);
    plan[7]  = mk_row(32'd10, 1, 0, 0, 0, 0, 0);
    // alternating extremes
    plan[8]  = mk_row(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    plan[9]  = mk_row(32'h0000_0000, 0, 0, 0, 0, 0, 0);
    plan[10] = mk_row(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    plan[11] = mk_row(32'h0000_0000, 1, 0, 0, 0, 0, 0);
    // sign-bit neighbors and a repeat in the middle
    plan[12] = mk_row(32'h8000_0000, 0, 0, 0, 0, 0, 0);
    plan[13] = mk_row(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    plan[14] = mk_row(32'h0000_0001, 0, 0, 0, 0, 0, 0);
    plan[15] = mk_row(32'h0000_0002, 0, 0, 0, 0, 0, 0);
    plan[16] = mk_row(32'h0000_0001, 0, 0, 0, 0, 0, 0);
    plan[17] = mk_row(32'hFFFF_FFFE, 1, 0, 0, 0, 0, 0);
    plan[18] = mk_row(32'h0000_0005, 1, 1, 32'h0000_0005, 7'd1, 1, 0);
    // set end carries a label already held
    plan[19] = mk_row(32'd9, 0, 0, 0, 0, 0, 0);
    plan[20] = mk_row(32'd4, 0, 0, 0, 0, 0, 0);
    plan[21] = mk_row(32'd9, 1, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_ROWS; i++)
      offer_label(plan[i].label, plan[i].fin, plan[i].typed, plan[i].want);

    random_sent = 0;
    set_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (set_idx < 2) kind = SET_FULL;
      else if ($urandom_range(0, 7) == 0) kind = SET_FULL;
      else if ($urandom_range(0, 1) == 0) kind = SET_FEW;
      else kind = SET_WIDE;

      // quiet stretch: no gaps and no stalls on either side
      idle_pct = (set_idx >= 3 && set_idx < 8) ? 0 : BUSY_PCT;
      // fill the block while the receiver holds off
      if (set_idx == 0) hold_wanted = 1'b1;

      case (kind)
        SET_FULL: begin
          if (set_idx == 0) n_new = MAX_DISTINCT + 4;
          else if (set_idx == 1) n_new = MAX_DISTINCT;
          else n_new = $urandom_range(MAX_DISTINCT - 2, MAX_DISTINCT + 6);
          step = $urandom_range(1, 1 << 25);
          off = $urandom;
          for (int i = 0; i < n_new; i++) batch[i] = off + i * step;
          n_rep = $urandom_range(0, 6);
          for (int i = 0; i < n_rep; i++) batch[n_new + i] = batch[$urandom_range(0, n_new - 1)];
          batch_len = n_new + n_rep;
        end
        SET_FEW: begin
          batch_len = $urandom_range(1, 10);
          for (int i = 0; i < batch_len; i++) batch[i] = $urandom_range(0, 15);
        end
        default: begin
          batch_len = $urandom_range(1, 12);
          for (int i = 0; i < batch_len; i++) begin
            case ($urandom_range(0, 9))
              0: batch[i] = 32'h0000_0000;
              1: batch[i] = 32'hFFFF_FFFF;
              default: batch[i] = $urandom;
            endcase
          end
        end
      endcase

      // shuffle arrival order
      for (int i = batch_len - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = batch[i];
        batch[i] = batch[j];
        batch[j] = tmp;
      end

      for (int i = 0; i < batch_len; i++)
        offer_label(batch[i], (i == batch_len - 1), 1'b0, none);
      random_sent += batch_len;
      set_idx++;
    end

    in_valid <= 1'b0;
    idle_pct = BUSY_PCT;
    while (awaited_uniques.size() != 0) @(posedge clk);
    repeat (MAX_DISTINCT + 16) @(posedge clk);

    $display("covered %0d labels in %0d sets, %0d results checked", items_sent,
             sets_closed, results_seen);
    $display("%0d sets overflowed the store, one long output hold-off", overflow_sets);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
